@@ hw/rtl/seconds_to_calendar_date_assert.svh @@
// ----------------------------------------------------------------------------
// seconds_to_calendar_date_assert.svh
// Assertion macros shared by the calendar conversion modules. Both expect
// aclk and aresetn in scope.
// ----------------------------------------------------------------------------
`ifndef SECONDS_TO_CALENDAR_DATE_ASSERT_SVH
`define SECONDS_TO_CALENDAR_DATE_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold at every edge out of reset
`define STCD_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("stcd: assertion failed");

// Antecedent in one cycle, consequent in the next
`define STCD_IMPLY_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("stcd: assertion failed");

`else

`define STCD_ASSERT(lbl, expr)
`define STCD_IMPLY_NEXT(lbl, ante, cons)

`endif

`endif

@@ hw/rtl/stcd_pkg.sv @@
// ----------------------------------------------------------------------------
// stcd_pkg
// Types, constants and helper functions for the seconds to calendar date
// converter.
// ----------------------------------------------------------------------------
package stcd_pkg;

    typedef struct packed {
        logic [31:0] seconds_count;
        logic [14:0] tick_count;
    } in_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  millisecond;
        logic [2:0]  weekday;
    } out_t;

    // Which constant division the datapath is working on
    typedef enum logic [1:0] {
        OP_DAY  = 2'd0,
        OP_HOUR = 2'd1,
        OP_MIN  = 2'd2,
        OP_WEEK = 2'd3
    } div_op_t;

    typedef struct packed {
        logic    load_in;
        logic    div_quo;
        logic    div_rem;
        div_op_t div_op;
        logic    year_step;
        logic    month_step;
        logic    load_out;
    } cmd_t;

    typedef struct packed {
        logic year_more;
        logic month_more;
    } status_t;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [11:0] SECS_PER_MIN  = 12'd60;
    localparam logic [15:0] DAYS_PER_WEEK = 16'd7;

    // Quotients by reciprocal multiply after stripping the power-of-two
    // factor: 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15. Each
    // reciprocal is 2^shift / divisor rounded up; the rounding error times
    // the largest operand stays below 2^shift, so the quotient is exact.
    localparam logic [25:0] RECIP_DAY  = 26'd50903317;
    localparam int unsigned SHIFT_DAY  = 35;
    localparam logic [13:0] RECIP_HOUR = 14'd9321;
    localparam int unsigned SHIFT_HOUR = 21;
    localparam logic [10:0] RECIP_MIN  = 11'd1093;
    localparam int unsigned SHIFT_MIN  = 14;
    localparam logic [16:0] RECIP_WEEK = 17'd74899;
    localparam int unsigned SHIFT_WEEK = 19;

    localparam logic [9:0]  MS_PER_SEC    = 10'd1000;
    localparam int unsigned TICK_BITS     = 15;
    localparam logic [2:0]  EPOCH_WEEKDAY = 3'd4;
    localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
    localparam logic [1:0]  EPOCH_MOD4    = 2'd2;
    localparam logic [6:0]  EPOCH_MOD100  = 7'd70;
    localparam logic [8:0]  EPOCH_MOD400  = 9'd370;
    localparam logic [6:0]  LAST_MOD100   = 7'd99;
    localparam logic [8:0]  LAST_MOD400   = 9'd399;
    localparam logic [8:0]  DAYS_YEAR     = 9'd365;
    localparam logic [8:0]  DAYS_LEAP     = 9'd366;

    function automatic logic [4:0] month_days(logic [3:0] month, logic leap);
        logic [4:0] n;
        case (month)
            4'd2:    n = leap ? 5'd29 : 5'd28;
            4'd4:    n = 5'd30;
            4'd6:    n = 5'd30;
            4'd9:    n = 5'd30;
            4'd11:   n = 5'd30;
            default: n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

@@ hw/rtl/stcd_datapath.sv @@
// ----------------------------------------------------------------------------
// stcd_datapath
// Constant divisions by reciprocal multiply, year and month walk registers
// and the result register of the calendar converter.
// ----------------------------------------------------------------------------
`include "seconds_to_calendar_date_assert.svh"

module stcd_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  stcd_pkg::in_t     in_data,
    input  stcd_pkg::cmd_t    cmd,
    output stcd_pkg::status_t status,
    output stcd_pkg::out_t    out_data
);

    logic [31:0] secs_reg;
    logic [15:0] days_reg;
    logic [16:0] rem_day_reg;
    logic [11:0] rem_hour_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  min_reg;
    logic [5:0]  sec_reg;
    logic [12:0] wq_reg;
    logic [2:0]  wday_reg;
    logic [9:0]  ms_reg;

    logic [16:0] day_reg;
    logic [11:0] year_reg;
    logic [1:0]  mod4_reg;
    logic [6:0]  mod100_reg;
    logic [8:0]  mod400_reg;
    logic [3:0]  month_reg;

    stcd_pkg::out_t out_reg;

    logic [50:0] day_prod;
    logic [15:0] days_next;
    logic [16:0] rem_day_next;
    logic [26:0] hour_prod;
    logic [4:0]  hour_next;
    logic [11:0] rem_hour_next;
    logic [20:0] min_prod;
    logic [5:0]  min_next;
    logic [5:0]  sec_next;
    logic [15:0] wnum;
    logic [32:0] week_prod;
    logic [12:0] wq_next;
    logic [2:0]  wday_next;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic [24:0] ms_prod;

    always_comb begin
        // quotient registered first, remainder from it in the next cycle
        day_prod     = 51'(secs_reg[31:7]) * 51'(stcd_pkg::RECIP_DAY);
        days_next    = 16'(day_prod >> stcd_pkg::SHIFT_DAY);
        rem_day_next = 17'(secs_reg - 32'(days_reg) * 32'(stcd_pkg::SECS_PER_DAY));

        hour_prod     = 27'(rem_day_reg[16:4]) * 27'(stcd_pkg::RECIP_HOUR);
        hour_next     = 5'(hour_prod >> stcd_pkg::SHIFT_HOUR);
        rem_hour_next = 12'(rem_day_reg - 17'(hour_reg) * stcd_pkg::SECS_PER_HOUR);

        min_prod = 21'(rem_hour_reg[11:2]) * 21'(stcd_pkg::RECIP_MIN);
        min_next = 6'(min_prod >> stcd_pkg::SHIFT_MIN);
        sec_next = 6'(rem_hour_reg - 12'(min_reg) * stcd_pkg::SECS_PER_MIN);

        wnum      = days_reg + 16'(stcd_pkg::EPOCH_WEEKDAY);
        week_prod = 33'(wnum) * 33'(stcd_pkg::RECIP_WEEK);
        wq_next   = 13'(week_prod >> stcd_pkg::SHIFT_WEEK);
        wday_next = 3'(wnum - 16'(wq_reg) * stcd_pkg::DAYS_PER_WEEK);

        leap = (mod4_reg == 2'd0 && mod100_reg != 7'd0) || mod400_reg == 9'd0;
        ylen = leap ? stcd_pkg::DAYS_LEAP : stcd_pkg::DAYS_YEAR;
        mlen = stcd_pkg::month_days(month_reg, leap);

        ms_prod = 25'(in_data.tick_count) * 25'(stcd_pkg::MS_PER_SEC);

        status.year_more  = day_reg > 17'(ylen);
        status.month_more = day_reg > 17'(mlen);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            secs_reg   <= in_data.seconds_count;
            ms_reg     <= ms_prod[24:stcd_pkg::TICK_BITS];
            year_reg   <= stcd_pkg::EPOCH_YEAR;
            mod4_reg   <= stcd_pkg::EPOCH_MOD4;
            mod100_reg <= stcd_pkg::EPOCH_MOD100;
            mod400_reg <= stcd_pkg::EPOCH_MOD400;
            month_reg  <= 4'd1;
        end
        if (cmd.div_quo) begin
            case (cmd.div_op)
                stcd_pkg::OP_DAY: begin
                    days_reg <= days_next;
                    day_reg  <= 17'(days_next) + 17'd1;
                end
                stcd_pkg::OP_HOUR: begin
                    hour_reg <= hour_next;
                end
                stcd_pkg::OP_MIN: begin
                    min_reg <= min_next;
                end
                stcd_pkg::OP_WEEK: begin
                    wq_reg <= wq_next;
                end
                default: begin
                end
            endcase
        end
        if (cmd.div_rem) begin
            case (cmd.div_op)
                stcd_pkg::OP_DAY: begin
                    rem_day_reg <= rem_day_next;
                end
                stcd_pkg::OP_HOUR: begin
                    rem_hour_reg <= rem_hour_next;
                end
                stcd_pkg::OP_MIN: begin
                    sec_reg <= sec_next;
                end
                stcd_pkg::OP_WEEK: begin
                    wday_reg <= wday_next;
                end
                default: begin
                end
            endcase
        end
        if (cmd.year_step) begin
            day_reg    <= day_reg - 17'(ylen);
            year_reg   <= year_reg + 12'd1;
            mod4_reg   <= mod4_reg + 2'd1;
            mod100_reg <= (mod100_reg == stcd_pkg::LAST_MOD100) ? 7'd0 : mod100_reg + 7'd1;
            mod400_reg <= (mod400_reg == stcd_pkg::LAST_MOD400) ? 9'd0 : mod400_reg + 9'd1;
        end
        if (cmd.month_step) begin
            day_reg   <= day_reg - 17'(mlen);
            month_reg <= month_reg + 4'd1;
        end
        if (cmd.load_out) begin
            out_reg.year         <= year_reg;
            out_reg.month        <= month_reg;
            out_reg.day_of_month <= day_reg[4:0];
            out_reg.hour         <= hour_reg;
            out_reg.minute       <= min_reg;
            out_reg.second       <= sec_reg;
            out_reg.millisecond  <= ms_reg;
            out_reg.weekday      <= wday_reg;
        end
    end

    assign out_data = out_reg;

    `STCD_ASSERT(a_out_month, !cmd.load_out || (month_reg >= 4'd1 && month_reg <= 4'd12))
    `STCD_ASSERT(a_out_day, !cmd.load_out || (day_reg >= 17'd1 && day_reg <= 17'd31))
    `STCD_IMPLY_NEXT(a_hour_range, cmd.div_quo && cmd.div_op == stcd_pkg::OP_HOUR, hour_reg <= 5'd23)
    `STCD_IMPLY_NEXT(a_wday_range, cmd.div_rem && cmd.div_op == stcd_pkg::OP_WEEK, wday_reg <= 3'd6)

endmodule

@@ hw/rtl/stcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// stcd_ctrl
// Sequencer for the calendar converter: runs the four divisions, the year
// walk and the month walk, then hands the result to the output register.
// ----------------------------------------------------------------------------
`include "seconds_to_calendar_date_assert.svh"

module stcd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  stcd_pkg::status_t status,
    output stcd_pkg::cmd_t    cmd
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_DAY_Q  = 12'b0000_0000_0010,
        S_DAY_R  = 12'b0000_0000_0100,
        S_HOUR_Q = 12'b0000_0000_1000,
        S_HOUR_R = 12'b0000_0001_0000,
        S_MIN_Q  = 12'b0000_0010_0000,
        S_MIN_R  = 12'b0000_0100_0000,
        S_WEEK_Q = 12'b0000_1000_0000,
        S_WEEK_R = 12'b0001_0000_0000,
        S_YEAR   = 12'b0010_0000_0000,
        S_MONTH  = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_op = stcd_pkg::OP_DAY;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DAY_Q;
                end
            end
            S_DAY_Q: begin
                cmd.div_quo = 1'b1;
                state_next  = S_DAY_R;
            end
            S_DAY_R: begin
                cmd.div_rem = 1'b1;
                state_next  = S_HOUR_Q;
            end
            S_HOUR_Q: begin
                cmd.div_quo = 1'b1;
                cmd.div_op  = stcd_pkg::OP_HOUR;
                state_next  = S_HOUR_R;
            end
            S_HOUR_R: begin
                cmd.div_rem = 1'b1;
                cmd.div_op  = stcd_pkg::OP_HOUR;
                state_next  = S_MIN_Q;
            end
            S_MIN_Q: begin
                cmd.div_quo = 1'b1;
                cmd.div_op  = stcd_pkg::OP_MIN;
                state_next  = S_MIN_R;
            end
            S_MIN_R: begin
                cmd.div_rem = 1'b1;
                cmd.div_op  = stcd_pkg::OP_MIN;
                state_next  = S_WEEK_Q;
            end
            S_WEEK_Q: begin
                cmd.div_quo = 1'b1;
                cmd.div_op  = stcd_pkg::OP_WEEK;
                state_next  = S_WEEK_R;
            end
            S_WEEK_R: begin
                cmd.div_rem = 1'b1;
                cmd.div_op  = stcd_pkg::OP_WEEK;
                state_next  = S_YEAR;
            end
            S_YEAR: begin
                if (status.year_more) begin
                    cmd.year_step = 1'b1;
                end else begin
                    state_next = S_MONTH;
                end
            end
            S_MONTH: begin
                if (status.month_more) begin
                    cmd.month_step = 1'b1;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `STCD_IMPLY_NEXT(a_accept_starts_div, s_valid && s_ready, state_reg == S_DAY_Q)
    `STCD_ASSERT(a_no_overwrite, !(cmd.load_out && m_valid_reg && !m_ready))
    `STCD_ASSERT(a_state_onehot, $onehot(state_reg))

endmodule

@@ hw/rtl/seconds_to_calendar_date.sv @@
// ----------------------------------------------------------------------------
// seconds_to_calendar_date
// Converts a seconds-since-1970 count plus 32768 Hz ticks into a Gregorian
// date, time of day, millisecond and weekday.
//
//   channel   ports               payload
//   input     s_valid / s_ready   s_data  (stcd_pkg::in_t)
//   result    m_valid / m_ready   m_data  (stcd_pkg::out_t)
//
// After a beat is accepted, the sequencer runs four constant divisions,
// each a quotient step and a remainder step, then the year and month
// walks (one step a cycle), and loads the result into the output register;
// s_ready rises again in the cycle after the load.
// Reset (aresetn low, synchronous) empties the output register and idles.
// A stalled result stays in the output register; the next beat is taken
// and worked on meanwhile, and waits only at hand-over.
// ----------------------------------------------------------------------------
module seconds_to_calendar_date (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  stcd_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output stcd_pkg::out_t m_data
);

    stcd_pkg::cmd_t    cmd;
    stcd_pkg::status_t status;

    stcd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    stcd_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_data  (s_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (m_data)
    );

endmodule

@@ dv/seconds_to_calendar_date_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seconds_to_calendar_date_tb
// Self-checking bench for the clock reading to calendar date converter.
// Readings go in over a valid/ready channel in random bursts; each accepted
// beat is converted by a behavioural calendar walk in the bench and queued,
// and every result beat is compared field by field with the oldest entry.
// The result side stalls on a random pattern, once for a long stretch.
// ----------------------------------------------------------------------------
module seconds_to_calendar_date_tb;

    localparam int unsigned SECONDS_PER_DAY  = 86400;
    localparam int unsigned SECONDS_PER_HOUR = 3600;
    localparam int unsigned FIRST_YEAR       = 1970;
    localparam int unsigned THURSDAY         = 4;
    localparam int unsigned TICKS_PER_SECOND = 32768;
    localparam int          DRAIN_CYCLES     = 400;
    localparam int          HOLD_CYCLES      = 2000;
    localparam int          CYCLE_LIMIT      = 800000;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    stcd_pkg::in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    stcd_pkg::out_t m_data;

    stcd_pkg::out_t date_q[$];
    int   err_count     = 0;
    int   sent_count    = 0;
    int   checked_count = 0;
    int   burst_left    = 1;
    int   cycle_count   = 0;
    logic hold_req      = 1'b0;
    logic rx_free       = 1'b0;

    seconds_to_calendar_date uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Calendar arithmetic
    // ------------------------------------------------------------------
    function automatic bit leap_year(int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int unsigned year_length(int unsigned y);
        return leap_year(y) ? 366 : 365;
    endfunction

    function automatic int unsigned month_length(int unsigned y, int unsigned m);
        case (m)
            2:       return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default: return 31;
        endcase
    endfunction

    function automatic stcd_pkg::out_t calendar_of(stcd_pkg::in_t rd);
        int unsigned    days;
        int unsigned    rem;
        int unsigned    yr;
        int unsigned    mon;
        int unsigned    dd;
        int unsigned    ticks;
        stcd_pkg::out_t r;
        days  = rd.seconds_count / SECONDS_PER_DAY;
        rem   = rd.seconds_count % SECONDS_PER_DAY;
        ticks = 32'(rd.tick_count);
        yr    = FIRST_YEAR;
        mon   = 1;
        dd    = days + 1;
        while (dd > year_length(yr)) begin
            dd -= year_length(yr);
            yr++;
        end
        while (dd > month_length(yr, mon)) begin
            dd -= month_length(yr, mon);
            mon++;
        end
        r.year         = yr[11:0];
        r.month        = mon[3:0];
        r.day_of_month = dd[4:0];
        r.hour         = 5'(rem / SECONDS_PER_HOUR);
        r.minute       = 6'((rem / 60) % 60);
        r.second       = 6'(rem % 60);
        r.millisecond  = 10'((ticks * 1000) / TICKS_PER_SECOND);
        r.weekday      = 3'((days + THURSDAY) % 7);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    // Leaves s_valid high; the caller either sends again or calls sender_gap.
    task automatic send_reading(stcd_pkg::in_t rd);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= rd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        date_q.push_back(calendar_of(rd));
        sent_count++;
    endtask

    task automatic sender_gap(int n);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    task automatic paced_send(logic [31:0] secs, logic [14:0] ticks);
        stcd_pkg::in_t rd;
        rd.seconds_count = secs;
        rd.tick_count    = ticks;
        send_reading(rd);
        burst_left--;
        if (burst_left <= 0) begin
            sender_gap($urandom_range(1, 30));
            burst_left = $urandom_range(1, 10);
        end
    endtask

    task automatic wait_for_drain();
        while (date_q.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall pattern changes mode every so often
    // ------------------------------------------------------------------
    initial begin : receiver
        int mode;
        int mode_left;
        int phase;
        int held;
        mode      = 0;
        mode_left = 0;
        phase     = 0;
        held      = 0;
        forever begin
            @(negedge aclk);
            if (hold_req && held == 0) begin
                held = 1;
                m_ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(negedge aclk);
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 200);
            end
            mode_left--;
            phase++;
            if (rx_free) begin
                m_ready <= 1'b1;
            end else begin
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= phase[2];
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        stcd_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (date_q.size() == 0) begin
                $error("result beat with no reading outstanding");
                err_count++;
            end else begin
                want = date_q.pop_front();
                checked_count++;
                check_field("year",         32'(want.year),         32'(m_data.year));
                check_field("month",        32'(want.month),        32'(m_data.month));
                check_field("day_of_month", 32'(want.day_of_month),
                            32'(m_data.day_of_month));
                check_field("hour",         32'(want.hour),         32'(m_data.hour));
                check_field("minute",       32'(want.minute),       32'(m_data.minute));
                check_field("second",       32'(want.second),       32'(m_data.second));
                check_field("millisecond",  32'(want.millisecond),
                            32'(m_data.millisecond));
                check_field("weekday",      32'(want.weekday),      32'(m_data.weekday));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, date_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_field_extremes();
        paced_send(32'd0,          15'd0);      // epoch
        paced_send(32'd0,          15'd32767);  // top tick count
        paced_send(32'hFFFF_FFFF,  15'd0);      // last representable second
        paced_send(32'hFFFF_FFFF,  15'd32767);
        paced_send(32'd86399,      15'd1);      // end of first day
        paced_send(32'd86400,      15'd16384);  // start of second day
        paced_send(32'd31535999,   15'd33);     // end of 1970
        paced_send(32'd68169600,   15'd32);     // leap day 1972
        paced_send(32'd946684799,  15'd100);    // end of 1999
        paced_send(32'd951782400,  15'd200);    // leap day 2000, 400 rule
        paced_send(32'd4107542399, 15'd300);    // 2100 is not a leap year
        paced_send(32'd4107542400, 15'd400);
        paced_send(32'd4233686400, 15'd500);    // leap day 2104
        paced_send(32'h7FFF_FFFF,  15'd1000);
        paced_send(32'h8000_0000,  15'd2000);
        paced_send(32'hAAAA_AAAA,  15'h5555);
        paced_send(32'h5555_5555,  15'h2AAA);
        paced_send(32'd3599,       15'd32766);  // hour roll-over
        paced_send(32'd3600,       15'd16383);
        sender_gap(1);
    endtask

    // Readings near year, month and day boundaries
    task automatic test_calendar_boundaries();
        int unsigned          yr;
        int unsigned          start;
        int unsigned          day_no;
        int unsigned          rem;
        longint unsigned      secs;
        for (int i = 0; i < 60; i++) begin
            yr    = $urandom_range(FIRST_YEAR, 2106);
            start = 0;
            for (int unsigned y = FIRST_YEAR; y < yr; y++) start += year_length(y);
            case ($urandom_range(0, 4))
                0:       day_no = (start > 0) ? start - 1 : 0;
                1:       day_no = start;
                2:       day_no = start + 58;
                3:       day_no = start + 59;
                default: day_no = start + $urandom_range(0, 365);
            endcase
            case ($urandom_range(0, 2))
                0:       rem = 0;
                1:       rem = SECONDS_PER_DAY - 1;
                default: rem = $urandom_range(0, SECONDS_PER_DAY - 1);
            endcase
            secs = longint'(day_no) * SECONDS_PER_DAY + rem;
            if (secs > 64'hFFFF_FFFF)
                secs = 64'hFFFF_FFFF - $urandom_range(0, 40 * SECONDS_PER_DAY);
            paced_send(secs[31:0], 15'($urandom_range(0, 32767)));
        end
        sender_gap(1);
    endtask

    task automatic test_random_readings();
        for (int i = 0; i < 170; i++)
            paced_send($urandom, 15'($urandom_range(0, 32767)));
        sender_gap($urandom_range(1, 20));
    endtask

    // Result side held off for a long stretch while readings keep coming
    task automatic test_output_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 20; i++)
            send_reading('{seconds_count: $urandom, tick_count: 15'($urandom)});
        sender_gap(1);
    endtask

    task automatic test_back_to_back();
        rx_free = 1'b1;
        for (int i = 0; i < 20; i++)
            send_reading('{seconds_count: $urandom, tick_count: 15'($urandom)});
        sender_gap(1);
        wait_for_drain();
        rx_free = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_field_extremes();
        wait_for_drain();
        test_calendar_boundaries();
        test_random_readings();
        wait_for_drain();
        test_output_backpressure();
        test_back_to_back();
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d readings sent, %0d dates checked: epoch and 2106 limits, leap days,",
                 sent_count, checked_count);
        $display("century rule, random readings, long output hold-off and back-to-back beats");
        if (err_count == 0 && date_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/stcd_pkg.sv
hw/rtl/stcd_datapath.sv
hw/rtl/stcd_ctrl.sv
hw/rtl/seconds_to_calendar_date.sv
dv/seconds_to_calendar_date_tb.sv
